// ----- src/assert_macros.svh -----
// Assertion macros used by the receive window RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off during reset
`define ASSERT_CLK(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Implication checked on the rising clock edge
`define ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

`endif

// ----- src/srej_pkg.sv -----
// Types, constants and codes for the SREJ receive window
package srej_pkg;

	localparam int WINDOW  = 16;
	localparam int MAX_LEN = 4095;
	localparam int IDX_W   = 4;
	localparam int WIN_W   = 5;

	localparam logic [2:0] KIND_SREJ   = 3'd0;
	localparam logic [2:0] KIND_RR     = 3'd1;
	localparam logic [2:0] KIND_DATA   = 3'd2;
	localparam logic [2:0] KIND_EOF    = 3'd3;
	localparam logic [2:0] KIND_DROP   = 3'd4;
	localparam logic [2:0] KIND_NOTICE = 3'd5;

	localparam logic [1:0] FLAG_DATA = 2'd0;
	localparam logic [1:0] FLAG_EOF  = 2'd1;

	localparam logic REG_START  = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	typedef struct packed {
		logic [31:0] pkt_seq;
		logic [1:0]  flag_class;
		logic        crc_ok;
		logic [15:0] payload_ref;
		logic [11:0] payload_len;
	} rx_word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] frame_seq;
		logic [31:0] ref_seq;
		logic [15:0] out_ref;
		logic [11:0] out_len;
		logic        last;
	} res_word_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] pref;
		logic [11:0] plen;
		logic        eof;
	} slot_t;

endpackage

// ----- src/srej_receive_window.sv -----
// Top level: selective-reject ARQ receive window with slot memory
// Usage:
//  rx channel (rx_valid/rx_ready/rx) takes one packet descriptor word; rx_ready
//  is high only while the sequencer is idle, so one word is worked at a time.
//  res channel (res_valid/res_ready/res) gives the result words of that packet
//  in order, the final one marked by last; a packet may give none.
//  Flow: an accepted word is decoded, then dropped, answered as stale (with a
//  notice for an end of file), stored silently, stored with SREJ requests, or
//  delivered; the first result word is registered after the decode state. An
//  in-order word also walks and drains the buffered packets that follow it,
//  the walk stopping at the window limit.
//  The result register frees the sequencer while a word waits: a stalled
//  receiver holds res steady and the sequencer waits on its next word.
//  APB port: register 0 start_sequence at 0x0, register 1 window_in_use at
//  0x4. Any write reinitialises the window; slot index setup then runs as a
//  bit-serial remainder of start_sequence by the window, during which rx_ready
//  is low.
//  Reset: start_sequence 1, window 16, all slots empty, ready after reset.
`include "assert_macros.svh"

module srej_receive_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  srej_pkg::rx_word_t   rx,
	output logic                 res_valid,
	input  logic                 res_ready,
	output srej_pkg::res_word_t  res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CFG, ST_INIT, ST_DEC, ST_DROP, ST_SRR, ST_NOTICE, ST_SREJ,
		ST_DELIV, ST_WRD, ST_WCK, ST_RR, ST_DRD, ST_DEM
	} state_t;

	state_t st_q;
	logic [31:0] start_q, exp_q, hs_q, own_q, it_q, s_q;
	logic [srej_pkg::WIN_W-1:0] win_q, cnt_q, steps_q, rem_q;
	logic [srej_pkg::IDX_W-1:0] eidx_q, sidx_q;
	logic [5:0] bit_q;
	logic [srej_pkg::WINDOW-1:0] valid_q;
	srej_pkg::rx_word_t pkt_q;
	srej_pkg::res_word_t res_q;
	logic res_v_q;

	srej_pkg::slot_t mem [srej_pkg::WINDOW];
	srej_pkg::slot_t rd_s1;
	logic mem_we, mem_re;
	logic [srej_pkg::IDX_W-1:0] rd_addr, wr_addr;
	srej_pkg::slot_t wr_data;

	logic [srej_pkg::WIN_W-1:0] weff;
	logic cfg_wr, can_emit, stale, bad, ooo_cur, ooo_nxt, idx_wrap, res_load;
	logic [31:0] seq_off;
	logic [srej_pkg::WIN_W-1:0] idx_sum;
	logic [srej_pkg::IDX_W-1:0] idx_in;
	logic [5:0] rem_sh;

	function automatic logic below(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic logic [srej_pkg::IDX_W-1:0] inc_idx(
		input logic [srej_pkg::IDX_W-1:0] i, input logic [srej_pkg::WIN_W-1:0] w);
		logic [srej_pkg::WIN_W-1:0] n;
		n = {1'b0, i} + 1'b1;
		return (n >= w) ? '0 : n[srej_pkg::IDX_W-1:0];
	endfunction

	// slot of seq + 1; number zero always sits in slot zero
	function automatic logic [srej_pkg::IDX_W-1:0] next_idx(
		input logic [srej_pkg::IDX_W-1:0] i, input logic [31:0] seq,
		input logic [srej_pkg::WIN_W-1:0] w);
		return (seq == '1) ? '0 : inc_idx(i, w);
	endfunction

	always_comb begin
		if (win_q == '0)
			weff = srej_pkg::WIN_W'(1);
		else if (32'(win_q) > srej_pkg::WINDOW)
			weff = srej_pkg::WIN_W'(srej_pkg::WINDOW);
		else
			weff = win_q;
	end

	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == srej_pkg::REG_WINDOW) ? {27'd0, win_q} : start_q;
	assign rx_ready = (st_q == ST_IDLE);
	assign res_valid = res_v_q;
	assign res      = res_q;
	assign can_emit = !res_v_q || res_ready;
	assign res_load = !cfg_wr && can_emit
		&& ((st_q inside {ST_DROP, ST_SRR, ST_NOTICE, ST_DELIV, ST_RR, ST_DEM})
		|| ((st_q == ST_SREJ) && ooo_cur));

	assign seq_off = pkt_q.pkt_seq - exp_q;
	assign stale   = below(pkt_q.pkt_seq, exp_q);
	assign bad     = (pkt_q.flag_class > srej_pkg::FLAG_EOF)
		|| (32'(pkt_q.payload_len) > srej_pkg::MAX_LEN) || (seq_off >= 32'(weff));
	assign idx_wrap = (pkt_q.pkt_seq < exp_q);
	assign idx_sum = {1'b0, eidx_q} + seq_off[srej_pkg::WIN_W-1:0];
	assign idx_in  = idx_wrap ? pkt_q.pkt_seq[srej_pkg::IDX_W-1:0]
		: (idx_sum >= weff) ? srej_pkg::IDX_W'(idx_sum - weff)
		: idx_sum[srej_pkg::IDX_W-1:0];
	assign ooo_cur = below(it_q, pkt_q.pkt_seq) && (({1'b0, cnt_q} + 6'd1) < {1'b0, weff});
	assign ooo_nxt = below(it_q + 32'd1, pkt_q.pkt_seq)
		&& (({1'b0, cnt_q} + 6'd2) < {1'b0, weff});
	assign rem_sh  = {rem_q, start_q[bit_q[4:0]]};

	assign mem_we  = (st_q == ST_DEC) && pkt_q.crc_ok && !stale && !bad && (seq_off != '0);
	assign wr_addr = idx_in;
	assign wr_data = '{seq: pkt_q.pkt_seq, pref: pkt_q.payload_ref,
		plen: pkt_q.payload_len, eof: (pkt_q.flag_class == srej_pkg::FLAG_EOF)};
	assign mem_re  = (st_q == ST_WRD) || (st_q == ST_DRD);
	assign rd_addr = (st_q == ST_DRD) ? sidx_q : eidx_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		if (mem_re)
			rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			start_q <= 32'd1;
			win_q   <= srej_pkg::WIN_W'(16);
			exp_q   <= 32'd1;
			own_q   <= 32'd1;
			hs_q    <= 32'd0;
			eidx_q  <= srej_pkg::IDX_W'(1);
			valid_q <= '0;
			res_v_q <= 1'b0;
			cnt_q   <= '0;
			steps_q <= '0;
			rem_q   <= '0;
			bit_q   <= '0;
			sidx_q  <= '0;
			it_q    <= '0;
			s_q     <= '0;
		end else begin
			if (res_load)
				res_v_q <= 1'b1;
			else if (res_ready)
				res_v_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == srej_pkg::REG_START)
					start_q <= pwdata;
				else
					win_q <= pwdata[srej_pkg::WIN_W-1:0];
				st_q <= ST_CFG;
			end else begin
				case (st_q)
					ST_IDLE: begin
						if (rx_valid) begin
							pkt_q <= rx;
							st_q  <= ST_DEC;
						end
					end
					ST_CFG: begin
						exp_q   <= start_q;
						own_q   <= start_q;
						hs_q    <= start_q - 32'd1;
						valid_q <= '0;
						rem_q   <= '0;
						bit_q   <= 6'd31;
						st_q    <= ST_INIT;
					end
					ST_INIT: begin
						rem_q <= (rem_sh >= {1'b0, weff}) ? srej_pkg::WIN_W'(rem_sh - {1'b0, weff})
							: rem_sh[srej_pkg::WIN_W-1:0];
						bit_q <= bit_q - 6'd1;
						if (bit_q == 6'h3f) begin
							eidx_q <= rem_q[srej_pkg::IDX_W-1:0];
							st_q   <= ST_IDLE;
						end
					end
					ST_DEC: begin
						if (!pkt_q.crc_ok)
							st_q <= ST_DROP;
						else if (stale)
							st_q <= ST_SRR;
						else if (bad)
							st_q <= ST_DROP;
						else begin
							if (below(hs_q, pkt_q.pkt_seq))
								hs_q <= pkt_q.pkt_seq;
							if (seq_off != '0) begin
								valid_q[idx_in] <= 1'b1;
								it_q  <= hs_q + 32'd1;
								cnt_q <= '0;
								st_q  <= ST_SREJ;
							end else
								st_q <= ST_DELIV;
						end
					end
					ST_DROP: begin
						if (can_emit) begin
							res_q   <= '{kind: srej_pkg::KIND_DROP, frame_seq: '0,
								ref_seq: pkt_q.pkt_seq, out_ref: '0, out_len: '0, last: 1'b1};
							st_q    <= ST_IDLE;
						end
					end
					ST_SRR: begin
						if (can_emit) begin
							res_q   <= '{kind: srej_pkg::KIND_RR, frame_seq: own_q, ref_seq: exp_q,
								out_ref: '0, out_len: '0,
								last: (pkt_q.flag_class != srej_pkg::FLAG_EOF)};
							own_q   <= own_q + 32'd1;
							st_q    <= (pkt_q.flag_class == srej_pkg::FLAG_EOF) ? ST_NOTICE : ST_IDLE;
						end
					end
					ST_NOTICE: begin
						if (can_emit) begin
							res_q   <= '{kind: srej_pkg::KIND_NOTICE, frame_seq: '0,
								ref_seq: pkt_q.pkt_seq, out_ref: '0, out_len: '0, last: 1'b1};
							st_q    <= ST_IDLE;
						end
					end
					ST_SREJ: begin
						if (!ooo_cur)
							st_q <= ST_IDLE;
						else if (can_emit) begin
							res_q   <= '{kind: srej_pkg::KIND_SREJ, frame_seq: own_q, ref_seq: it_q,
								out_ref: '0, out_len: '0, last: !ooo_nxt};
							own_q   <= own_q + 32'd1;
							it_q    <= it_q + 32'd1;
							cnt_q   <= cnt_q + 1'b1;
							if (!ooo_nxt)
								st_q <= ST_IDLE;
						end
					end
					ST_DELIV: begin
						if (can_emit) begin
							res_q   <= '{kind: (pkt_q.flag_class == srej_pkg::FLAG_EOF)
								? srej_pkg::KIND_EOF : srej_pkg::KIND_DATA, frame_seq: '0,
								ref_seq: pkt_q.pkt_seq, out_ref: pkt_q.payload_ref,
								out_len: pkt_q.payload_len, last: 1'b0};
							exp_q   <= exp_q + 32'd1;
							eidx_q  <= next_idx(eidx_q, exp_q, weff);
							sidx_q  <= next_idx(eidx_q, exp_q, weff);
							s_q     <= pkt_q.pkt_seq + 32'd1;
							steps_q <= '0;
							st_q    <= ST_WRD;
						end
					end
					ST_WRD: begin
						st_q <= (({1'b0, steps_q} + 6'd1) < {1'b0, weff}) ? ST_WCK : ST_RR;
					end
					ST_WCK: begin
						if (valid_q[eidx_q] && (rd_s1.seq == exp_q)) begin
							exp_q   <= exp_q + 32'd1;
							eidx_q  <= next_idx(eidx_q, exp_q, weff);
							steps_q <= steps_q + 1'b1;
							st_q    <= ST_WRD;
						end else
							st_q <= ST_RR;
					end
					ST_RR: begin
						if (can_emit) begin
							res_q   <= '{kind: srej_pkg::KIND_RR, frame_seq: own_q, ref_seq: exp_q,
								out_ref: '0, out_len: '0, last: (s_q == exp_q)};
							own_q   <= own_q + 32'd1;
							st_q    <= (s_q == exp_q) ? ST_IDLE : ST_DRD;
						end
					end
					ST_DRD: begin
						st_q <= ST_DEM;
					end
					ST_DEM: begin
						if (can_emit) begin
							res_q   <= '{kind: rd_s1.eof ? srej_pkg::KIND_EOF : srej_pkg::KIND_DATA,
								frame_seq: '0, ref_seq: rd_s1.seq, out_ref: rd_s1.pref,
								out_len: rd_s1.plen, last: ((s_q + 32'd1) == exp_q)};
							valid_q[sidx_q] <= 1'b0;
							s_q     <= s_q + 32'd1;
							sidx_q  <= next_idx(sidx_q, s_q, weff);
							st_q    <= ((s_q + 32'd1) == exp_q) ? ST_IDLE : ST_DRD;
						end
					end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

	`ASSERT_IMPL(a_eidx_in_window, st_q == ST_IDLE, {1'b0, eidx_q} < weff)
	`ASSERT_IMPL(a_drain_idx_in_window, st_q == ST_DRD, {1'b0, sidx_q} < weff)
	`ASSERT_IMPL(a_drain_slot_filled, st_q == ST_DEM, valid_q[sidx_q])

endmodule
